// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/stc_pkg.sv =====
// Shared constants and types of the Taylor-series sine core.
// No dependencies; used by every module of the core.
`timescale 1ns / 1ps

package stc_pkg;

    localparam int MAX_TERMS = 8;
    localparam int FRAC_BITS = 28;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 4;

    localparam logic [CFG_W-1:0] TERM_COUNT_RESET = 4'd5;

    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // The square is never negative, so one bit less than a data word holds it.
    localparam int SQ_W        = DATA_W - 1;
    localparam int PROD_W      = 2 * DATA_W;
    // Magnitude of a shifted term product: at most 2^(2*DATA_W-2-FRAC_BITS).
    localparam int MAG_W       = 2 * DATA_W - 1 - FRAC_BITS;
    // Low magnitude bits left out of the reciprocal multiply.
    localparam int DROP_W      = MAG_W - DATA_W;
    localparam int RECIP_SHIFT = DATA_W - 1;

    typedef struct packed {
        logic signed [DATA_W-1:0] term;
        logic signed [DATA_W-1:0] sum;
        logic [SQ_W-1:0]          sq;
        logic                     flag;
    } t_cell_bus;

endpackage

// ===== hdl/stc_square.sv =====
// Head cell of the series chain: clamps the term count, squares the angle.
// Depends on stc_pkg.
`timescale 1ns / 1ps

module stc_square #(
    parameter int MAX_TERMS = stc_pkg::MAX_TERMS,
    parameter int CNT_W     = $clog2(MAX_TERMS + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [stc_pkg::DATA_W-1:0]   i_angle,
    input  logic [stc_pkg::CFG_W-1:0]           i_term_count,
    output logic                                o_valid,
    output stc_pkg::t_cell_bus                  o_bus,
    output logic [CNT_W-1:0]                    o_count
);

    localparam int FracBits = stc_pkg::FRAC_BITS;
    localparam int SqW      = stc_pkg::SQ_W;
    localparam int ProdW    = stc_pkg::PROD_W;

    logic                                r_a_valid;
    logic signed [stc_pkg::DATA_W-1:0]   r_a_x;
    logic [CNT_W-1:0]                    r_a_cnt;
    logic signed [ProdW-1:0]             r_a_prod;
    logic [CNT_W-1:0]                    n_cnt;
    logic signed [ProdW-1:0]             n_prod;

    logic                                r_b_valid;
    stc_pkg::t_cell_bus                  r_b_bus;
    logic [CNT_W-1:0]                    r_b_cnt;
    stc_pkg::t_cell_bus                  n_bus;
    logic                                w_sq_over;

    always_comb begin
        if (i_term_count == '0) begin
            n_cnt = CNT_W'(1);
        end else if (int'(i_term_count) > MAX_TERMS) begin
            n_cnt = CNT_W'(MAX_TERMS);
        end else begin
            n_cnt = CNT_W'(i_term_count);
        end
    end

    assign n_prod = i_angle * i_angle;

    // The square is nonnegative; any set bit above the kept field is an overflow.
    assign w_sq_over = |r_a_prod[ProdW-1:FracBits+SqW];

    always_comb begin
        n_bus.term = r_a_x;
        n_bus.sum  = r_a_x;
        n_bus.flag = w_sq_over;
        if (w_sq_over) begin
            n_bus.sq = {SqW{1'b1}};
        end else begin
            n_bus.sq = r_a_prod[FracBits+SqW-1:FracBits];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_x    <= i_angle;
            r_a_cnt  <= n_cnt;
            r_a_prod <= n_prod;
            r_b_bus  <= n_bus;
            r_b_cnt  <= r_a_cnt;
        end
    end

    assign o_valid = r_b_valid;
    assign o_bus   = r_b_bus;
    assign o_count = r_b_cnt;

endmodule

// ===== hdl/stc_term_cell.sv =====
// One series cell: forms the next term from the previous one and adds it.
// Depends on stc_pkg; five register stages, advanced by a common enable.
`timescale 1ns / 1ps

module stc_term_cell #(
    parameter int INDEX = 1,
    parameter int CNT_W = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  stc_pkg::t_cell_bus  i_bus,
    input  logic [CNT_W-1:0]    i_count,
    output logic                o_valid,
    output stc_pkg::t_cell_bus  o_bus,
    output logic [CNT_W-1:0]    o_count
);

    localparam int DataW      = stc_pkg::DATA_W;
    localparam int ProdW      = stc_pkg::PROD_W;
    localparam int MagW       = stc_pkg::MAG_W;
    localparam int DropW      = stc_pkg::DROP_W;
    localparam int RecipShift = stc_pkg::RECIP_SHIFT;

    // Divisor 2i(2i+1) and its scaled reciprocal, fixed for this cell.
    localparam int unsigned     Div       = 2 * INDEX * (2 * INDEX + 1);
    localparam int              DivW      = $clog2(Div + 1);
    localparam int              RemW      = DivW + 2;
    localparam longint unsigned RecipFull = (64'd1 << (RecipShift + DropW)) / Div;
    localparam logic [DataW-1:0] Recip    = DataW'(RecipFull);
    localparam logic [DivW-1:0]  DivC     = DivW'(Div);
    localparam logic [RemW-1:0]  Div1     = RemW'(Div);
    localparam logic [RemW-1:0]  Div2     = RemW'(2 * Div);
    localparam logic [RemW-1:0]  Div3     = RemW'(3 * Div);
    localparam logic [DataW:0]   QPosLim  = {2'b00, {(DataW-1){1'b1}}};
    localparam logic [DataW:0]   QNegLim  = {2'b01, {(DataW-1){1'b0}}};

    // Valid and count travel alongside the payload through all stages.
    logic [4:0]             r_valid;
    logic [CNT_W-1:0]       r_cnt [0:4];
    stc_pkg::t_cell_bus     r_bus [0:4];

    logic signed [ProdW-1:0] r1_prod;
    logic signed [ProdW-1:0] n1_prod;

    logic signed [ProdW-1:0] w_neg_prod;
    logic signed [ProdW-1:0] w_shifted;
    logic signed [MagW:0]    w_a;
    logic [MagW:0]           w_a_neg;
    logic                    n2_neg;
    logic [MagW-1:0]         n2_mag;
    logic                    r2_neg;
    logic [MagW-1:0]         r2_mag;

    logic [ProdW-1:0]        n3_qp;
    logic [ProdW-1:0]        r3_qp;
    logic                    r3_neg;
    logic [MagW-1:0]         r3_mag;

    logic [DataW-1:0]        w_q0;
    logic [MagW-1:0]         w_q0d;
    logic [MagW-1:0]         w_rem_full;
    logic [DataW-1:0]        r4_q0;
    logic [RemW-1:0]         r4_rem;
    logic                    r4_neg;

    logic [1:0]              w_inc;
    logic [DataW:0]          w_q;
    logic signed [DataW-1:0] w_term;
    logic                    w_term_clip;
    logic signed [DataW:0]   w_sum_wide;
    logic                    w_active;
    stc_pkg::t_cell_bus      n5_bus;

    // Stage 1: term times square.
    assign n1_prod = i_bus.term * $signed({1'b0, i_bus.sq});

    // Stage 2: negate, shift down, split into sign and magnitude.
    assign w_neg_prod = -r1_prod;
    assign w_shifted  = w_neg_prod >>> stc_pkg::FRAC_BITS;
    assign w_a        = w_shifted[MagW:0];
    assign w_a_neg    = (MagW + 1)'(-w_a);
    assign n2_neg     = w_a[MagW];
    assign n2_mag     = n2_neg ? w_a_neg[MagW-1:0] : w_a[MagW-1:0];

    // Stage 3: estimate of the quotient, never above the true one.
    assign n3_qp = ProdW'(r2_mag[MagW-1:DropW]) * ProdW'(Recip);

    // Stage 4: remainder of the estimate; it stays below four divisors.
    assign w_q0       = r3_qp[RecipShift +: DataW];
    assign w_q0d      = MagW'(w_q0) * MagW'(DivC);
    assign w_rem_full = r3_mag - w_q0d;

    // Stage 5: correct the quotient, restore the sign, clip, accumulate.
    assign w_inc = {1'b0, r4_rem >= Div1} + {1'b0, r4_rem >= Div2}
                 + {1'b0, r4_rem >= Div3};
    assign w_q   = {1'b0, r4_q0} + (DataW + 1)'(w_inc);

    always_comb begin
        w_term_clip = 1'b0;
        if (!r4_neg) begin
            if (w_q > QPosLim) begin
                w_term      = stc_pkg::Q_MAX;
                w_term_clip = 1'b1;
            end else begin
                w_term = $signed(w_q[DataW-1:0]);
            end
        end else begin
            if (w_q > QNegLim) begin
                w_term      = stc_pkg::Q_MIN;
                w_term_clip = 1'b1;
            end else begin
                w_term = $signed(DataW'(-w_q));
            end
        end
    end

    assign w_sum_wide = {r_bus[3].sum[DataW-1], r_bus[3].sum} + {w_term[DataW-1], w_term};
    assign w_active   = CNT_W'(INDEX) < r_cnt[3];

    always_comb begin
        n5_bus = r_bus[3];
        if (w_active) begin
            n5_bus.term = w_term;
            n5_bus.flag = r_bus[3].flag | w_term_clip;
            if (w_sum_wide[DataW] != w_sum_wide[DataW-1]) begin
                n5_bus.sum  = w_sum_wide[DataW] ? stc_pkg::Q_MIN : stc_pkg::Q_MAX;
                n5_bus.flag = 1'b1;
            end else begin
                n5_bus.sum = w_sum_wide[DataW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bus[0] <= i_bus;
            r_cnt[0] <= i_count;
            r_bus[1] <= r_bus[0];
            r_cnt[1] <= r_cnt[0];
            r_bus[2] <= r_bus[1];
            r_cnt[2] <= r_cnt[1];
            r_bus[3] <= r_bus[2];
            r_cnt[3] <= r_cnt[2];
            r_bus[4] <= n5_bus;
            r_cnt[4] <= r_cnt[3];
            r1_prod  <= n1_prod;
            r2_neg   <= n2_neg;
            r2_mag   <= n2_mag;
            r3_qp    <= n3_qp;
            r3_neg   <= r2_neg;
            r3_mag   <= r2_mag;
            r4_q0    <= w_q0;
            r4_rem   <= w_rem_full[RemW-1:0];
            r4_neg   <= r3_neg;
        end
    end

    assign o_valid = r_valid[4];
    assign o_bus   = r_bus[4];
    assign o_count = r_cnt[4];

endmodule

// ===== hdl/sine_taylor_series_core.sv =====
// Top level of the Taylor-series sine core: head cell plus a chain of term cells.
// Depends on stc_pkg, stc_square and stc_term_cell.
`timescale 1ns / 1ps
//
// Usage notes.
// The input channel (i_angle_valid / o_angle_ready / i_angle) takes one word per
// transfer: an angle in signed Q4.28 radians. The output channel (o_sine_valid /
// i_sine_ready / o_sine / o_saturated) returns one word per angle, in order: the
// sum of the first term_count Maclaurin terms, saturated to Q4.28, and a flag
// that is set when the square, any term or any partial sum was clipped.
// The user writes the term count through i_term_count_we / i_term_count only
// while the core is idle; the block itself does not enforce this. Zero counts
// as one term and values above MAX_TERMS clamp. Each angle passes through the
// head cell, which registers the angle and then its square, then through each
// of the MAX_TERMS-1 term cells, which register one multiply, sign and magnitude,
// a reciprocal multiply, a remainder, and correction and accumulation in turn.
// All cells advance together, so one word is accepted in every cycle while the
// output is not stalled; no stage of a cell forms more than one product.
// When the receiver stalls with a word waiting, the whole chain freezes and
// o_angle_ready drops until that word is taken. Synchronous reset empties the
// pipeline and returns the term count to five.

module sine_taylor_series_core #(
    parameter int MAX_TERMS = stc_pkg::MAX_TERMS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_angle_valid,
    output logic                                o_angle_ready,
    input  logic signed [stc_pkg::DATA_W-1:0]   i_angle,
    output logic                                o_sine_valid,
    input  logic                                i_sine_ready,
    output logic signed [stc_pkg::DATA_W-1:0]   o_sine,
    output logic                                o_saturated,
    input  logic                                i_term_count_we,
    input  logic [stc_pkg::CFG_W-1:0]           i_term_count
);

    localparam int CntW = $clog2(MAX_TERMS + 1);

    logic [stc_pkg::CFG_W-1:0] r_term_count;

    // Chain wiring: entry k is the output of the cell that produced term k.
    logic                  w_valid [0:MAX_TERMS-1];
    stc_pkg::t_cell_bus    w_bus   [0:MAX_TERMS-1];
    logic [CntW-1:0]       w_cnt   [0:MAX_TERMS-1];
    logic                  w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= stc_pkg::TERM_COUNT_RESET;
        end else if (i_term_count_we) begin
            r_term_count <= i_term_count;
        end
    end

    // The last cell's register is the output register; the chain moves whenever
    // it is empty or being read.
    assign w_adv = !w_valid[MAX_TERMS-1] || i_sine_ready;

    stc_square #(
        .MAX_TERMS (MAX_TERMS),
        .CNT_W     (CntW)
    ) u_square (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_adv),
        .i_valid      (i_angle_valid),
        .i_angle      (i_angle),
        .i_term_count (r_term_count),
        .o_valid      (w_valid[0]),
        .o_bus        (w_bus[0]),
        .o_count      (w_cnt[0])
    );

    for (genvar k = 1; k < MAX_TERMS; k++) begin : g_cell
        stc_term_cell #(
            .INDEX (k),
            .CNT_W (CntW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_valid[k-1]),
            .i_bus   (w_bus[k-1]),
            .i_count (w_cnt[k-1]),
            .o_valid (w_valid[k]),
            .o_bus   (w_bus[k]),
            .o_count (w_cnt[k])
        );
    end

    assign o_angle_ready = w_adv;
    assign o_sine_valid  = w_valid[MAX_TERMS-1];
    assign o_sine        = w_bus[MAX_TERMS-1].sum;
    assign o_saturated   = w_bus[MAX_TERMS-1].flag;

endmodule

// ===== hdl/stc_checker.sv =====
// Port-level checks of the Taylor-series sine core, bound to its top level.
// Depends on stc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_angle_valid,
    input logic                                o_angle_ready,
    input logic signed [stc_pkg::DATA_W-1:0]   i_angle,
    input logic                                o_sine_valid,
    input logic                                i_sine_ready,
    input logic signed [stc_pkg::DATA_W-1:0]   o_sine,
    input logic                                o_saturated
);

    // A waiting angle word stays offered and keeps its value.
    `ASSERT_CLK(a_in_hold, i_clk, i_rst_n, i_angle_valid && !o_angle_ready |=> i_angle_valid && $stable(i_angle), "angle word dropped or changed while waiting")

    // A waiting result word stays offered.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_sine_valid && !i_sine_ready |=> o_sine_valid, "result word dropped while stalled")

    // A waiting result word keeps its value.
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, o_sine_valid && !i_sine_ready |=> $stable(o_sine) && $stable(o_saturated), "result word changed while stalled")

    // A stalled output freezes the chain, so no new angle may enter.
    `ASSERT_CLK(a_stall_blocks_in, i_clk, i_rst_n, o_sine_valid && !i_sine_ready |-> !o_angle_ready, "angle accepted while output stalled")

    // Reset empties the pipeline.
    `ASSERT_CLK_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_sine_valid, "result offered right after reset")

endmodule

bind sine_taylor_series_core stc_checker u_stc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_angle_valid (i_angle_valid),
    .o_angle_ready (o_angle_ready),
    .i_angle       (i_angle),
    .o_sine_valid  (o_sine_valid),
    .i_sine_ready  (i_sine_ready),
    .o_sine        (o_sine),
    .o_saturated   (o_saturated)
);
